// ===== src/s2l_pkg.sv =====
package s2l_pkg;

    localparam int IN_BITS = 8;
    localparam int OUT_FRAC_BITS = 8;
    localparam int Q = 24;
    localparam int LIN_BITS = Q + 1;
    localparam int NUM_BITS = 48;
    localparam int F_NUM_BITS = 39;

    localparam longint unsigned M = (64'd1 << IN_BITS) - 64'd1;
    localparam longint unsigned ONE_Q = 64'd1 << Q;

    localparam logic [23:0] C_XR = 24'd4124564;
    localparam logic [23:0] C_XG = 24'd3575761;
    localparam logic [23:0] C_XB = 24'd1804375;
    localparam logic [23:0] C_YR = 24'd2126729;
    localparam logic [23:0] C_YG = 24'd7151522;
    localparam logic [23:0] C_YB = 24'd721750;
    localparam logic [23:0] C_ZR = 24'd193339;
    localparam logic [23:0] C_ZG = 24'd1191920;
    localparam logic [23:0] C_ZB = 24'd9503041;

    localparam logic [23:0] BIAS_X = 24'd4752350;
    localparam logic [23:0] BIAS_Y = 24'd5000000;
    localparam logic [23:0] BIAS_Z = 24'd5444150;

    localparam longint unsigned DIV_X = 64'd9504700;
    localparam longint unsigned DIV_Y = 64'd10000000;
    localparam longint unsigned DIV_Z = 64'd10888300;
    localparam longint unsigned DIV_F = 64'd3132;

    localparam logic [14:0] L_MAX = 15'(100 << OUT_FRAC_BITS);

    typedef struct packed {
        logic [IN_BITS-1:0] red;
        logic [IN_BITS-1:0] green;
        logic [IN_BITS-1:0] blue;
    } pix_t;

    typedef struct packed {
        logic [14:0]        lightness;
        logic signed [15:0] green_red;
        logic signed [15:0] blue_yellow;
    } lab_t;

    function automatic longint unsigned pow5_q(input longint unsigned r);
        longint unsigned p;
        p = r;
        for (int i = 0; i < 4; i++)
            p = (p * r) >> Q;
        return p;
    endfunction

    // sRGB inverse gamma in Q24, evaluated at elaboration;
    // lin_low is the linear-segment value, t the scaled base of the power segment
    function automatic logic [LIN_BITS-1:0] lin_q24(input longint unsigned v,
                                                    input longint unsigned lin_low,
                                                    input longint unsigned t);
        longint unsigned t2;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        if (v * 64'd100000 <= 64'd4045 * M)
            return LIN_BITS'(lin_low);
        t2 = (t * t) >> Q;
        lo = 64'd0;
        hi = ONE_Q + 64'd1;
        while (hi - lo > 64'd1) begin
            mid = lo + ((hi - lo) >> 1);
            if (pow5_q(mid) <= t2)
                lo = mid;
            else
                hi = mid;
        end
        return LIN_BITS'((t2 * lo) >> Q);
    endfunction

endpackage

// ===== src/srgb_to_cielab_unit.sv =====
// channel | dir | handshake              | word
// pix     | in  | pix_valid / pix_stall  | s2l_pkg::pix_t (red, green, blue)
// lab     | out | lab_valid / lab_stall  | s2l_pkg::lab_t (lightness, green_red, blue_yellow)
//
// One pixel per cycle sustained while the output is not stalled.
// Most of the pipeline depth lies in the cube root: two register stages per result bit, 25 bits.
// rst_n clears every valid bit; data registers are not reset.
// A stalled result holds the whole pipeline in place; pix_stall follows
// lab_valid && lab_stall, so no word is dropped or repeated.
module srgb_to_cielab_unit (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          pix_valid,
    output logic          pix_stall,
    input  s2l_pkg::pix_t pix,
    output logic          lab_valid,
    input  logic          lab_stall,
    output s2l_pkg::lab_t lab
);

    localparam int FB = s2l_pkg::LIN_BITS;
    localparam int SH = s2l_pkg::Q - s2l_pkg::OUT_FRAC_BITS;
    localparam int XB = 38;

    logic          en;
    logic          gv, mv, fxv, fyv, fzv;
    logic [FB-1:0] lr, lg, lb, xr, yr, zr, fx, fy, fz;

    logic                 o1v_reg, o2v_reg;
    logic signed [XB-1:0] l1_reg, a1_reg, b1_reg;
    logic signed [XB-1:0] fxs, fys, fzs;
    logic signed [XB-1:0] lsh, ash, bsh;
    s2l_pkg::lab_t        lab_reg, lab_next;

    assign en        = !(o2v_reg && lab_stall);
    assign pix_stall = !en;

    s2l_gamma u_gamma (
        .clk(clk), .rst_n(rst_n), .en(en), .valid_in(pix_valid), .pix(pix),
        .valid_out(gv), .lin_r(lr), .lin_g(lg), .lin_b(lb)
    );

    s2l_matrix u_matrix (
        .clk(clk), .rst_n(rst_n), .en(en), .valid_in(gv),
        .lin_r(lr), .lin_g(lg), .lin_b(lb),
        .valid_out(mv), .xr(xr), .yr(yr), .zr(zr)
    );

    s2l_cie_f u_f_x (
        .clk(clk), .rst_n(rst_n), .en(en), .valid_in(mv), .w(xr),
        .valid_out(fxv), .f(fx)
    );

    s2l_cie_f u_f_y (
        .clk(clk), .rst_n(rst_n), .en(en), .valid_in(mv), .w(yr),
        .valid_out(fyv), .f(fy)
    );

    s2l_cie_f u_f_z (
        .clk(clk), .rst_n(rst_n), .en(en), .valid_in(mv), .w(zr),
        .valid_out(fzv), .f(fz)
    );

    assign fxs = XB'(fx);
    assign fys = XB'(fy);
    assign fzs = XB'(fz);

    // round half up, then floor shift
    assign lsh = (l1_reg + (XB'(1) <<< (SH - 1))) >>> SH;
    assign ash = (a1_reg + (XB'(1) <<< (SH - 1))) >>> SH;
    assign bsh = (b1_reg + (XB'(1) <<< (SH - 1))) >>> SH;

    always_comb
    begin
        if (lsh < 0)
            lab_next.lightness = '0;
        else if (lsh > XB'(s2l_pkg::L_MAX))
            lab_next.lightness = s2l_pkg::L_MAX;
        else
            lab_next.lightness = 15'(lsh);

        if (ash > XB'(32767))
            lab_next.green_red = 16'sh7fff;
        else if (ash < -XB'(32768))
            lab_next.green_red = -16'sh8000;
        else
            lab_next.green_red = 16'(ash);

        if (bsh > XB'(32767))
            lab_next.blue_yellow = 16'sh7fff;
        else if (bsh < -XB'(32768))
            lab_next.blue_yellow = -16'sh8000;
        else
            lab_next.blue_yellow = 16'(bsh);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o1v_reg <= 1'b0;
            o2v_reg <= 1'b0;
        end
        else if (en)
        begin
            o1v_reg <= fxv & fyv & fzv;
            o2v_reg <= o1v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            l1_reg  <= XB'(116) * fys - (XB'(16) <<< s2l_pkg::Q);
            a1_reg  <= XB'(500) * (fxs - fys);
            b1_reg  <= XB'(200) * (fys - fzs);
            lab_reg <= lab_next;
        end
    end

    assign lab_valid = o2v_reg;
    assign lab       = lab_reg;

    a_l_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        lab_valid |-> lab.lightness <= s2l_pkg::L_MAX)
        else $error("lightness above full scale");

    a_f_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (fxv == fyv) && (fyv == fzv))
        else $error("cube root lanes out of step");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        pix_stall |=> $stable(l1_reg) && $stable(o1v_reg))
        else $error("pipeline moved while stalled");

endmodule

// ===== src/s2l_cdiv.sv =====
module s2l_cdiv #(
    parameter int              N_BITS    = 48,
    parameter longint unsigned DIVISOR   = 64'd9504700,
    parameter int              PASS_BITS = 1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         valid_in,
    input  logic [N_BITS-1:0]            num,
    input  logic [PASS_BITS-1:0]         pass_in,
    output logic                         valid_out,
    output logic [N_BITS-$clog2(DIVISOR):0] quo,
    output logic [PASS_BITS-1:0]         pass_out
);

    localparam int K = $clog2(DIVISOR) - 1;
    localparam int Q_BITS = N_BITS - K;
    localparam int D_BITS = $clog2(DIVISOR);
    localparam logic [31:0] RECIP = 32'((64'd1 << (K + 32)) / DIVISOR);
    localparam logic [D_BITS-1:0] DV = D_BITS'(DIVISOR);

    logic                 v1_reg, v2_reg, v3_reg;
    logic [Q_BITS-1:0]    est1_reg, est2_reg, quo_reg;
    logic [N_BITS-1:0]    num1_reg, num2_reg, prod2_reg;
    logic [PASS_BITS-1:0] pass1_reg, pass2_reg, pass3_reg;

    logic [Q_BITS+31:0]       est_full;
    logic [Q_BITS+D_BITS-1:0] prod_full;
    logic [N_BITS-1:0]        rem_fin;
    logic [N_BITS-1:0]        rem;
    logic [Q_BITS-1:0]        quo_next;

    assign est_full  = num[N_BITS-1:K] * RECIP;
    assign prod_full = est1_reg * DV;
    assign rem       = num2_reg - prod2_reg;

    // estimate is low by at most two
    always_comb
    begin
        if (rem >= N_BITS'(2 * DIVISOR))
        begin
            quo_next = est2_reg + Q_BITS'(2);
            rem_fin  = rem - N_BITS'(2 * DIVISOR);
        end
        else if (rem >= N_BITS'(DIVISOR))
        begin
            quo_next = est2_reg + Q_BITS'(1);
            rem_fin  = rem - N_BITS'(DIVISOR);
        end
        else
        begin
            quo_next = est2_reg;
            rem_fin  = rem;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= valid_in;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            est1_reg  <= Q_BITS'(est_full >> 32);
            num1_reg  <= num;
            pass1_reg <= pass_in;
            est2_reg  <= est1_reg;
            prod2_reg <= N_BITS'(prod_full);
            num2_reg  <= num1_reg;
            pass2_reg <= pass1_reg;
            quo_reg   <= quo_next;
            pass3_reg <= pass2_reg;
        end
    end

    assign valid_out = v3_reg;
    assign quo       = quo_reg;
    assign pass_out  = pass3_reg;

    a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg |-> rem_fin < N_BITS'(DIVISOR))
        else $error("quotient correction left remainder too large");

endmodule

// ===== src/s2l_gamma.sv =====
module s2l_gamma (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic                            valid_in,
    input  s2l_pkg::pix_t                   pix,
    output logic                            valid_out,
    output logic [s2l_pkg::LIN_BITS-1:0]    lin_r,
    output logic [s2l_pkg::LIN_BITS-1:0]    lin_g,
    output logic [s2l_pkg::LIN_BITS-1:0]    lin_b
);

    localparam int DEPTH = 2 ** s2l_pkg::IN_BITS;

    logic [s2l_pkg::LIN_BITS-1:0] lut [DEPTH];
    logic                         v_reg;
    logic [s2l_pkg::LIN_BITS-1:0] r_reg, g_reg, b_reg;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_lut
        localparam longint unsigned LOW_Q =
            (64'(i) * 64'd100 * s2l_pkg::ONE_Q + 64'd646 * s2l_pkg::M)
            / (64'd1292 * s2l_pkg::M);
        localparam longint unsigned T_Q =
            ((64'd1000 * 64'(i) + 64'd55 * s2l_pkg::M) * s2l_pkg::ONE_Q
             + 64'd527 * s2l_pkg::M) / (64'd1055 * s2l_pkg::M);
        localparam logic [s2l_pkg::LIN_BITS-1:0] LIN_Q =
            s2l_pkg::lin_q24(64'(i), LOW_Q, T_Q);
        assign lut[i] = LIN_Q;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (en)
            v_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg <= lut[pix.red];
            g_reg <= lut[pix.green];
            b_reg <= lut[pix.blue];
        end
    end

    assign valid_out = v_reg;
    assign lin_r     = r_reg;
    assign lin_g     = g_reg;
    assign lin_b     = b_reg;

endmodule

// ===== src/s2l_matrix.sv =====
module s2l_matrix (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         valid_in,
    input  logic [s2l_pkg::LIN_BITS-1:0] lin_r,
    input  logic [s2l_pkg::LIN_BITS-1:0] lin_g,
    input  logic [s2l_pkg::LIN_BITS-1:0] lin_b,
    output logic                         valid_out,
    output logic [s2l_pkg::LIN_BITS-1:0] xr,
    output logic [s2l_pkg::LIN_BITS-1:0] yr,
    output logic [s2l_pkg::LIN_BITS-1:0] zr
);

    localparam int NB = s2l_pkg::NUM_BITS;
    localparam int PB = s2l_pkg::LIN_BITS + 24;

    logic          v1_reg, v2_reg;
    logic [PB-1:0] px_reg [3];
    logic [PB-1:0] py_reg [3];
    logic [PB-1:0] pz_reg [3];
    logic [NB-1:0] nx_reg, ny_reg, nz_reg;
    logic [NB+1:0] sx, sy, sz;
    logic          vx, vy, vz;

    assign sx = (NB+2)'(px_reg[0]) + (NB+2)'(px_reg[1]) + (NB+2)'(px_reg[2])
              + (NB+2)'(s2l_pkg::BIAS_X);
    assign sy = (NB+2)'(py_reg[0]) + (NB+2)'(py_reg[1]) + (NB+2)'(py_reg[2])
              + (NB+2)'(s2l_pkg::BIAS_Y);
    assign sz = (NB+2)'(pz_reg[0]) + (NB+2)'(pz_reg[1]) + (NB+2)'(pz_reg[2])
              + (NB+2)'(s2l_pkg::BIAS_Z);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= valid_in;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg[0] <= lin_r * s2l_pkg::C_XR;
            px_reg[1] <= lin_g * s2l_pkg::C_XG;
            px_reg[2] <= lin_b * s2l_pkg::C_XB;
            py_reg[0] <= lin_r * s2l_pkg::C_YR;
            py_reg[1] <= lin_g * s2l_pkg::C_YG;
            py_reg[2] <= lin_b * s2l_pkg::C_YB;
            pz_reg[0] <= lin_r * s2l_pkg::C_ZR;
            pz_reg[1] <= lin_g * s2l_pkg::C_ZG;
            pz_reg[2] <= lin_b * s2l_pkg::C_ZB;
            nx_reg    <= NB'(sx);
            ny_reg    <= NB'(sy);
            nz_reg    <= NB'(sz);
        end
    end

    s2l_cdiv #(.N_BITS(NB), .DIVISOR(s2l_pkg::DIV_X), .PASS_BITS(1)) u_div_x (
        .clk(clk), .rst_n(rst_n), .en(en), .valid_in(v2_reg), .num(nx_reg),
        .pass_in(1'b0), .valid_out(vx), .quo(xr), .pass_out()
    );

    s2l_cdiv #(.N_BITS(NB), .DIVISOR(s2l_pkg::DIV_Y), .PASS_BITS(1)) u_div_y (
        .clk(clk), .rst_n(rst_n), .en(en), .valid_in(v2_reg), .num(ny_reg),
        .pass_in(1'b0), .valid_out(vy), .quo(yr), .pass_out()
    );

    s2l_cdiv #(.N_BITS(NB), .DIVISOR(s2l_pkg::DIV_Z), .PASS_BITS(1)) u_div_z (
        .clk(clk), .rst_n(rst_n), .en(en), .valid_in(v2_reg), .num(nz_reg),
        .pass_in(1'b0), .valid_out(vz), .quo(zr), .pass_out()
    );

    assign valid_out = vx & vy & vz;

endmodule

// ===== src/s2l_cie_f.sv =====
module s2l_cie_f (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         valid_in,
    input  logic [s2l_pkg::LIN_BITS-1:0] w,
    output logic                         valid_out,
    output logic [s2l_pkg::LIN_BITS-1:0] f
);

    localparam int FB = s2l_pkg::LIN_BITS;
    localparam int NB = s2l_pkg::F_NUM_BITS;
    localparam int QB = NB - $clog2(s2l_pkg::DIV_F) + 1;
    localparam logic [NB-1:0] THRESH = NB'(216) << s2l_pkg::Q;
    localparam logic [NB-1:0] LIN_OFS = (NB'(432) << s2l_pkg::Q) + NB'(1566);

    logic          v0_reg;
    logic          sel0_reg;
    logic [FB-1:0] w0_reg;
    logic [NB-1:0] num0_reg;
    logic [NB-1:0] wk;

    logic          dv;
    logic [QB-1:0] dq;
    logic [FB:0]   dpass;

    // per-bit root stages, index s holds the state entering step s
    logic            v_st   [FB+1];
    logic            sel_st [FB+1];
    logic [FB-1:0]   w_st   [FB+1];
    logic [FB-1:0]   lin_st [FB+1];
    logic [FB-1:0]   c_st   [FB+1];
    logic [2*FB-1:0] sq_st  [FB+1];

    logic          vo_reg;
    logic [FB-1:0] f_reg;

    assign wk = NB'(w) * NB'(24389);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else if (en)
            v0_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            w0_reg   <= w;
            sel0_reg <= wk > THRESH;
            num0_reg <= wk + LIN_OFS;
        end
    end

    s2l_cdiv #(.N_BITS(NB), .DIVISOR(s2l_pkg::DIV_F), .PASS_BITS(FB+1)) u_div (
        .clk(clk), .rst_n(rst_n), .en(en), .valid_in(v0_reg), .num(num0_reg),
        .pass_in({sel0_reg, w0_reg}), .valid_out(dv), .quo(dq), .pass_out(dpass)
    );

    assign v_st[0]   = dv;
    assign sel_st[0] = dpass[FB];
    assign w_st[0]   = dpass[FB-1:0];
    assign lin_st[0] = FB'(dq);
    assign c_st[0]   = '0;
    assign sq_st[0]  = '0;

    for (genvar s = 0; s < FB; s++)
    begin : g_root
        localparam int K = FB - 1 - s;

        logic            va_reg, vb_reg;
        logic            sela_reg, selb_reg;
        logic [FB-1:0]   wa_reg, wb_reg, lina_reg, linb_reg;
        logic [FB-1:0]   ca_reg, ta_reg, cb_reg;
        logic [2*FB-1:0] sqa_reg, tsqa_reg, sqb_reg;
        logic [2*FB-1:0] tsq;
        logic [2*FB:0]   cube;
        logic            fits;

        // exact square of the trial value, built from the running square
        assign tsq = sq_st[s] + ((2*FB)'(c_st[s]) << (K + 1))
                   + ((2*FB)'(1) << (2 * K));
        assign cube = tsqa_reg[2*FB-1:s2l_pkg::Q] * ta_reg;
        assign fits = cube[2*FB:s2l_pkg::Q] <= (2*FB+1-s2l_pkg::Q)'(wa_reg);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                va_reg <= 1'b0;
                vb_reg <= 1'b0;
            end
            else if (en)
            begin
                va_reg <= v_st[s];
                vb_reg <= va_reg;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sela_reg <= sel_st[s];
                wa_reg   <= w_st[s];
                lina_reg <= lin_st[s];
                ca_reg   <= c_st[s];
                sqa_reg  <= sq_st[s];
                ta_reg   <= c_st[s] | (FB'(1) << K);
                tsqa_reg <= tsq;
                selb_reg <= sela_reg;
                wb_reg   <= wa_reg;
                linb_reg <= lina_reg;
                cb_reg   <= fits ? ta_reg : ca_reg;
                sqb_reg  <= fits ? tsqa_reg : sqa_reg;
            end
        end

        assign v_st[s+1]   = vb_reg;
        assign sel_st[s+1] = selb_reg;
        assign w_st[s+1]   = wb_reg;
        assign lin_st[s+1] = linb_reg;
        assign c_st[s+1]   = cb_reg;
        assign sq_st[s+1]  = sqb_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vo_reg <= 1'b0;
        else if (en)
            vo_reg <= v_st[FB];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            f_reg <= sel_st[FB] ? c_st[FB] : lin_st[FB];
    end

    assign valid_out = vo_reg;
    assign f         = f_reg;

endmodule

// ===== bench/srgb_to_cielab_unit_check.sv =====
`timescale 1ns / 100ps

module srgb_to_cielab_unit_check (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          pix_valid,
    input  logic          pix_stall,
    input  s2l_pkg::pix_t pix,
    input  logic          lab_valid,
    input  logic          lab_stall,
    input  s2l_pkg::lab_t lab,
    output int            errors,
    output int            pending,
    output int            checked
);

    localparam longint unsigned ONE = 64'd1 << 24;

    s2l_pkg::lab_t lab_due[$];

    function automatic longint unsigned cube_q(input longint unsigned c);
        return (((c * c) >> 24) * c) >> 24;
    endfunction

    function automatic longint unsigned fifth_q(input longint unsigned c);
        longint unsigned p;
        p = c;
        for (int i = 0; i < 4; i++)
            p = (p * c) >> 24;
        return p;
    endfunction

    function automatic longint unsigned gamma_lin(
        input logic [s2l_pkg::IN_BITS-1:0] code);
        longint unsigned m, v, t, t2, lo, hi, mid;
        m = (64'd1 << s2l_pkg::IN_BITS) - 1;
        v = code;
        if (v * 100000 <= 4045 * m)
            return (v * 100 * ONE + 646 * m) / (1292 * m);
        t = ((1000 * v + 55 * m) * ONE + 527 * m) / (1055 * m);
        t2 = (t * t) >> 24;
        lo = 0;
        hi = ONE + 1;
        while (hi - lo > 1)
        begin
            mid = lo + ((hi - lo) >> 1);
            if (fifth_q(mid) <= t2) lo = mid; else hi = mid;
        end
        return (t2 * lo) >> 24;
    endfunction

    function automatic longint lab_f(input longint unsigned w);
        longint unsigned lo, hi, mid;
        if (w * 24389 > 216 * ONE)
        begin
            lo = 0;
            hi = 64'd1 << 26;
            while (hi - lo > 1)
            begin
                mid = lo + ((hi - lo) >> 1);
                if (cube_q(mid) <= w) lo = mid; else hi = mid;
            end
            return longint'(lo);
        end
        return longint'((w * 24389 + 432 * ONE + 1566) / 3132);
    endfunction

    function automatic longint to_out(input longint x);
        return (x + (longint'(1) << (23 - s2l_pkg::OUT_FRAC_BITS)))
            >>> (24 - s2l_pkg::OUT_FRAC_BITS);
    endfunction

    function automatic logic [15:0] clip16(input longint x);
        if (x > 32767) x = 32767;
        if (x < -32768) x = -32768;
        return x[15:0];
    endfunction

    function automatic s2l_pkg::lab_t pixel_to_lab(input s2l_pkg::pix_t p);
        longint unsigned r, g, b, xr, yr, zr;
        longint fx, fy, fz, l;
        s2l_pkg::lab_t o;
        r = gamma_lin(p.red);
        g = gamma_lin(p.green);
        b = gamma_lin(p.blue);
        xr = (4124564 * r + 3575761 * g + 1804375 * b + 4752350) / 9504700;
        yr = (2126729 * r + 7151522 * g + 721750 * b + 5000000) / 10000000;
        zr = (193339 * r + 1191920 * g + 9503041 * b + 5444150) / 10888300;
        fx = lab_f(xr);
        fy = lab_f(yr);
        fz = lab_f(zr);
        l = to_out(116 * fy - 16 * longint'(ONE));
        if (l < 0) l = 0;
        if (l > (100 << s2l_pkg::OUT_FRAC_BITS)) l = 100 << s2l_pkg::OUT_FRAC_BITS;
        o.lightness = l[14:0];
        o.green_red = clip16(to_out(500 * (fx - fy)));
        o.blue_yellow = clip16(to_out(200 * (fy - fz)));
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        s2l_pkg::lab_t want;
        if (!rst_n)
        begin
            errors <= 0;
            checked <= 0;
            pending <= 0;
            lab_due.delete();
        end
        else
        begin
            if (pix_valid && !pix_stall)
                lab_due.push_back(pixel_to_lab(pix));
            if (lab_valid && !lab_stall)
            begin
                checked <= checked + 1;
                if (lab_due.size() == 0)
                begin
                    errors <= errors + 1;
                    if (errors < 10)
                        $display("unexpected lab word %h", lab);
                end
                else
                begin
                    want = lab_due.pop_front();
                    if (want !== lab)
                    begin
                        errors <= errors + 1;
                        if (errors < 10)
                            $display("mismatch: L %0d/%0d a %0d/%0d b %0d/%0d",
                                want.lightness, lab.lightness,
                                want.green_red, lab.green_red,
                                want.blue_yellow, lab.blue_yellow);
                    end
                end
            end
            pending <= lab_due.size();
        end
    end
endmodule

// ===== bench/srgb_to_cielab_unit_test.sv =====
`timescale 1ns / 100ps

module srgb_to_cielab_unit_test;

    logic          clk;
    logic          rst_n;
    logic          pix_valid;
    logic          pix_stall;
    s2l_pkg::pix_t pix;
    logic          lab_valid;
    logic          lab_stall;
    s2l_pkg::lab_t lab;
    int            errors;
    int            pending;
    int            checked;
    int            cycles;
    int            sent;
    bit            calm;
    bit            hold_req;
    bit            hold_done;

    srgb_to_cielab_unit u_top (.*);

    srgb_to_cielab_unit_check u_check (.*);

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > 400000)
            begin
                $display("timeout");
                $display("** srgb_to_cielab_unit: FAILED **");
                $finish;
            end
        end
    end

    // receiver: random stall bursts, one long hold-off on request
    initial
    begin
        int n;
        lab_stall <= 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                lab_stall <= 1;
                for (n = 0; n < 200; n++) @(posedge clk);
                lab_stall <= 0;
                hold_done = 1;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                lab_stall <= 1;
                n = $urandom_range(1, 9);
                repeat (n) @(posedge clk);
                lab_stall <= 0;
            end
        end
    end

    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        int gap;
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            pix_valid <= 0;
            gap = $urandom_range(1, 9);
            repeat (gap) @(posedge clk);
        end
        pix_valid <= 1;
        pix <= '{red: r, green: g, blue: b};
        @(posedge clk);
        while (pix_stall) @(posedge clk);
        sent++;
    endtask

    task automatic drain;
        pix_valid <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    initial
    begin
        logic [7:0] lv[10];
        int c, k;
        lv = '{8'd0, 8'd1, 8'd10, 8'd11, 8'd127, 8'd128, 8'd170, 8'd254, 8'd255, 8'd85};
        rst_n = 0;
        pix_valid = 0;
        pix = '0;
        sent = 0;
        calm = 0;
        hold_req = 0;
        hold_done = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // corners, primaries, gamma knee, saturating chroma
        for (k = 0; k < 8; k++)
            send_pixel(k[0] ? 8'hFF : 8'h00, k[1] ? 8'hFF : 8'h00, k[2] ? 8'hFF : 8'h00);
        send_pixel(8'd10, 8'd10, 8'd10);
        send_pixel(8'd11, 8'd11, 8'd11);
        send_pixel(8'd1, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd1);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd254, 8'd254, 8'd254);
        send_pixel(8'd255, 8'd0, 8'd255);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'h55, 8'hAA, 8'h55);
        send_pixel(8'hAA, 8'h55, 8'hAA);
        drain();
        for (c = 0; c < 1150; c++)
        begin
            if (c == 300)
            begin
                hold_req = 1;
            end
            if (c == 600)
                drain();
            if (c >= 1000)
                calm = 1;
            if ($urandom_range(0, 3) == 0)
                send_pixel(lv[$urandom_range(0, 9)], lv[$urandom_range(0, 9)],
                    lv[$urandom_range(0, 9)]);
            else
                send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
        end
        drain();
        repeat (80) @(posedge clk);
        $display("%0d pixels sent, %0d lab words checked, incl. long output hold-off",
            sent, checked);
        if (errors == 0 && pending == 0)
            $display("** srgb_to_cielab_unit: PASSED **");
        else
            $display("** srgb_to_cielab_unit: FAILED **");
        $finish;
    end
endmodule

// ===== files.f =====
src/s2l_pkg.sv
src/s2l_cdiv.sv
src/s2l_gamma.sv
src/s2l_matrix.sv
src/s2l_cie_f.sv
src/srgb_to_cielab_unit.sv
bench/srgb_to_cielab_unit_check.sv
bench/srgb_to_cielab_unit_test.sv
